>>> design/tmie_pkg.sv
// ----------------------------------------------------------------------------
// Tape machine executor package
// Shared constants, instruction codes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package tmie_pkg;

	// Default store sizes.
	localparam int TAPE_DEPTH_DEF = 32768;
	localparam int CODE_DEPTH_DEF = 4096;

	// Request kinds.
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_STEP = 1'b1;

	// Instruction characters.
	localparam logic [7:0] OP_RIGHT = 8'h3E;  // '>'
	localparam logic [7:0] OP_LEFT  = 8'h3C;  // '<'
	localparam logic [7:0] OP_INC   = 8'h2B;  // '+'
	localparam logic [7:0] OP_DEC   = 8'h2D;  // '-'
	localparam logic [7:0] OP_OUT   = 8'h2E;  // '.'
	localparam logic [7:0] OP_IN    = 8'h2C;  // ','
	localparam logic [7:0] OP_OPEN  = 8'h5B;  // '['
	localparam logic [7:0] OP_CLOSE = 8'h5D;  // ']'

	// Run status codes.
	typedef enum logic [2:0] {
		ST_RUN     = 3'd0,
		ST_HALT    = 3'd1,
		ST_PTR     = 3'd2,
		ST_BRACKET = 3'd3,
		ST_FULL    = 3'd4
	} tmie_status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_DONE
	} tmie_state_t;

endpackage

>>> design/tmie_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries load and step transactions.
// ----------------------------------------------------------------------------
interface tmie_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] code_byte;
	logic [7:0] feed_byte;

	modport source (output valid, output req_type, output code_byte, output feed_byte,
		input ready);
	modport sink (input valid, input req_type, input code_byte, input feed_byte,
		output ready);
endinterface

>>> design/tmie_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result transaction per request.
// ----------------------------------------------------------------------------
interface tmie_rsp_if;
	logic       valid;
	logic       ready;
	logic       emit_valid;
	logic [7:0] emit_byte;
	logic       feed_taken;
	logic [2:0] status;

	modport source (output valid, output emit_valid, output emit_byte,
		output feed_taken, output status, input ready);
	modport sink (input valid, input emit_valid, input emit_byte,
		input feed_taken, input status, output ready);
endinterface

>>> design/tape_machine_instruction_executor_top.sv
// ----------------------------------------------------------------------------
// Tape machine instruction executor
// Top level: sequencer with its code memory and tape memory.
// ----------------------------------------------------------------------------
// After reset the block clears the tape one cell per cycle and accepts no
// transaction until that pass ends. Then each request takes one transaction
// at a time: a load or a step with no work goes straight to the done state,
// a plain instruction passes through execute first (code and tape read,
// execute, result), and a bracket jump adds a read and a check state per code
// byte scanned, plus one more read if the scan runs off the code unmatched,
// since it reads code memory through its single read port one byte at a time.
// A new request is taken while the last result waits on the response side.
module tape_machine_instruction_executor_top #(
	parameter int TAPE_DEPTH = tmie_pkg::TAPE_DEPTH_DEF,
	parameter int CODE_DEPTH = tmie_pkg::CODE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tmie_req_if.sink    req,
	tmie_rsp_if.source  rsp
);
	import tmie_pkg::*;

	localparam int TAW = $clog2(TAPE_DEPTH);
	localparam int CAW = $clog2(CODE_DEPTH);

	logic           tape_we;
	logic [TAW-1:0] tape_waddr;
	logic [7:0]     tape_wdata;
	logic [TAW-1:0] tape_raddr;
	logic [7:0]     tape_rdata;
	logic           code_we;
	logic [CAW-1:0] code_waddr;
	logic [7:0]     code_wdata;
	logic [CAW-1:0] code_raddr;
	logic [7:0]     code_rdata;

	// Sequencer and datapath.
	tmie_seq #(
		.TAPE_DEPTH (TAPE_DEPTH),
		.CODE_DEPTH (CODE_DEPTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.tape_we    (tape_we),
		.tape_waddr (tape_waddr),
		.tape_wdata (tape_wdata),
		.tape_raddr (tape_raddr),
		.tape_rdata (tape_rdata),
		.code_we    (code_we),
		.code_waddr (code_waddr),
		.code_wdata (code_wdata),
		.code_raddr (code_raddr),
		.code_rdata (code_rdata)
	);

	// Tape memory.
	tmie_ram #(
		.DEPTH (TAPE_DEPTH),
		.WIDTH (8)
	) u_tape (
		.clk   (clk),
		.we    (tape_we),
		.waddr (tape_waddr),
		.wdata (tape_wdata),
		.raddr (tape_raddr),
		.rdata (tape_rdata)
	);

	// Code memory.
	tmie_ram #(
		.DEPTH (CODE_DEPTH),
		.WIDTH (8)
	) u_code (
		.clk   (clk),
		.we    (code_we),
		.waddr (code_waddr),
		.wdata (code_wdata),
		.raddr (code_raddr),
		.rdata (code_rdata)
	);

endmodule

>>> design/tmie_ram.sv
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tmie_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> design/tmie_seq.sv
// ----------------------------------------------------------------------------
// Executor sequencer
// Runs the clearing pass, loads code, executes one instruction per step
// transaction and scans code memory for matching brackets.
// ----------------------------------------------------------------------------
module tmie_seq #(
	parameter int TAPE_DEPTH = tmie_pkg::TAPE_DEPTH_DEF,
	parameter int CODE_DEPTH = tmie_pkg::CODE_DEPTH_DEF,
	localparam int TAW = $clog2(TAPE_DEPTH),
	localparam int CAW = $clog2(CODE_DEPTH)
) (
	input  logic            clk,
	input  logic            arst_n,
	tmie_req_if.sink        req,
	tmie_rsp_if.source      rsp,
	output logic            tape_we,
	output logic [TAW-1:0]  tape_waddr,
	output logic [7:0]      tape_wdata,
	output logic [TAW-1:0]  tape_raddr,
	input  logic [7:0]      tape_rdata,
	output logic            code_we,
	output logic [CAW-1:0]  code_waddr,
	output logic [7:0]      code_wdata,
	output logic [CAW-1:0]  code_raddr,
	input  logic [7:0]      code_rdata
);
	import tmie_pkg::*;

	localparam int CW = $clog2(CODE_DEPTH + 1);
	localparam logic [TAW-1:0] TAPE_LAST = TAW'(TAPE_DEPTH - 1);
	localparam logic [CW-1:0]  CODE_FULL = CW'(CODE_DEPTH);

	tmie_state_t  state_q, state_d;
	tmie_status_t status_q, status_set;

	logic [TAW-1:0] clr_q;
	logic [CW-1:0]  len_q;
	logic [CW-1:0]  ic_q;
	logic [TAW-1:0] ptr_q;
	logic           rsp_valid_q;

	logic [7:0]     feed_q;
	logic           ev_q;
	logic [7:0]     eb_q;
	logic           ft_q;
	logic [CW-1:0]  scan_q;
	logic [CW-1:0]  depth_q;
	logic           fwd_q;
	logic           scan_end_q;
	logic [7:0]     rsp_eb_q;
	logic           rsp_ev_q;
	logic           rsp_ft_q;
	logic [2:0]     rsp_st_q;

	logic accept;
	logic err;
	logic slot_free;
	logic jump;
	logic scan_out;
	logic scan_same;
	logic scan_opp;
	logic scan_hit;

	// Common decode terms.
	assign accept    = req.valid && req.ready;
	assign err       = (status_q == ST_PTR) || (status_q == ST_BRACKET) ||
		(status_q == ST_FULL);
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign jump      = ((code_rdata == OP_OPEN) && (tape_rdata == 8'd0)) ||
		((code_rdata == OP_CLOSE) && (tape_rdata != 8'd0));
	assign scan_out  = fwd_q ? (scan_q >= len_q) : scan_end_q;
	assign scan_same = fwd_q ? (code_rdata == OP_OPEN) : (code_rdata == OP_CLOSE);
	assign scan_opp  = fwd_q ? (code_rdata == OP_CLOSE) : (code_rdata == OP_OPEN);
	assign scan_hit  = scan_opp && (depth_q == CW'(1));
	assign status_set = err ? status_q : ((ic_q >= len_q) ? ST_HALT : ST_RUN);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == TAPE_LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (!err && (req.req_type == REQ_STEP) && (ic_q < len_q)) begin
						state_d = S_EXEC;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_EXEC: begin
				state_d = jump ? S_SCAN_RD : S_DONE;
			end
			S_SCAN_RD: begin
				state_d = scan_out ? S_DONE : S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				state_d = scan_hit ? S_DONE : S_SCAN_RD;
			end
			S_DONE: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	// Output logic: handshake and memory controls.
	always_comb begin
		req.ready  = 1'b0;
		tape_we    = 1'b0;
		tape_waddr = ptr_q;
		tape_wdata = 8'd0;
		tape_raddr = ptr_q;
		code_we    = 1'b0;
		code_waddr = len_q[CAW-1:0];
		code_wdata = req.code_byte;
		code_raddr = ic_q[CAW-1:0];
		case (state_q)
			S_CLEAR: begin
				tape_we    = 1'b1;
				tape_waddr = clr_q;
			end
			S_IDLE: begin
				req.ready = 1'b1;
				code_we   = req.valid && !err && (req.req_type == REQ_LOAD) &&
					(len_q != CODE_FULL);
			end
			S_EXEC: begin
				case (code_rdata)
					OP_INC: begin
						tape_we    = 1'b1;
						tape_wdata = tape_rdata + 8'd1;
					end
					OP_DEC: begin
						tape_we    = 1'b1;
						tape_wdata = tape_rdata - 8'd1;
					end
					OP_IN: begin
						tape_we    = 1'b1;
						tape_wdata = feed_q;
					end
					default: begin
						tape_we = 1'b0;
					end
				endcase
			end
			S_SCAN_RD: begin
				code_raddr = scan_q[CAW-1:0];
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			status_q    <= ST_RUN;
			clr_q       <= '0;
			len_q       <= '0;
			ic_q        <= '0;
			ptr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// A waiting result leaves when taken; the done state loads the next one.
			if (rsp.ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + TAW'(1);
				end
				S_IDLE: begin
					if (accept && !err && (req.req_type == REQ_LOAD)) begin
						if (len_q == CODE_FULL) begin
							status_q <= ST_FULL;
						end else begin
							len_q <= len_q + CW'(1);
						end
					end
				end
				S_EXEC: begin
					case (code_rdata)
						OP_RIGHT: begin
							if (ptr_q == TAPE_LAST) begin
								status_q <= ST_PTR;
							end else begin
								ptr_q <= ptr_q + TAW'(1);
								ic_q  <= ic_q + CW'(1);
							end
						end
						OP_LEFT: begin
							if (ptr_q == '0) begin
								status_q <= ST_PTR;
							end else begin
								ptr_q <= ptr_q - TAW'(1);
								ic_q  <= ic_q + CW'(1);
							end
						end
						default: begin
							if (!jump) begin
								ic_q <= ic_q + CW'(1);
							end
						end
					endcase
				end
				S_SCAN_RD: begin
					if (scan_out) begin
						status_q <= ST_BRACKET;
					end
				end
				S_SCAN_CHK: begin
					// Execution resumes just past the matching bracket.
					if (scan_hit) begin
						ic_q <= scan_q + CW'(1);
					end
				end
				S_DONE: begin
					if (slot_free) begin
						status_q    <= status_set;
						rsp_valid_q <= 1'b1;
					end
				end
				default: begin
					clr_q <= clr_q;
				end
			endcase
		end
	end

	// Payload registers: feed byte, result fields and bracket scan state.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					feed_q <= req.feed_byte;
					ev_q   <= 1'b0;
					eb_q   <= 8'd0;
					ft_q   <= 1'b0;
				end
			end
			S_EXEC: begin
				if (code_rdata == OP_OUT) begin
					ev_q <= 1'b1;
					eb_q <= tape_rdata;
				end
				if (code_rdata == OP_IN) begin
					ft_q <= 1'b1;
				end
				fwd_q      <= (code_rdata == OP_OPEN);
				depth_q    <= CW'(1);
				scan_end_q <= (code_rdata == OP_CLOSE) && (ic_q == '0);
				scan_q     <= (code_rdata == OP_OPEN) ? (ic_q + CW'(1)) : (ic_q - CW'(1));
			end
			S_SCAN_CHK: begin
				if (scan_same) begin
					depth_q <= depth_q + CW'(1);
				end else if (scan_opp) begin
					depth_q <= depth_q - CW'(1);
				end
				if (!fwd_q && (scan_q == '0)) begin
					scan_end_q <= 1'b1;
				end
				scan_q <= fwd_q ? (scan_q + CW'(1)) : (scan_q - CW'(1));
			end
			S_DONE: begin
				if (slot_free) begin
					rsp_ev_q <= err ? 1'b0 : ev_q;
					rsp_eb_q <= err ? 8'd0 : eb_q;
					rsp_ft_q <= err ? 1'b0 : ft_q;
					rsp_st_q <= status_set;
				end
			end
			default: begin
				feed_q <= feed_q;
			end
		endcase
	end

	// Response channel.
	assign rsp.valid      = rsp_valid_q;
	assign rsp.emit_valid = rsp_ev_q;
	assign rsp.emit_byte  = rsp_eb_q;
	assign rsp.feed_taken = rsp_ft_q;
	assign rsp.status     = rsp_st_q;

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tape machine instruction executor testbench
// Loads short programs into the block and single-steps them, predicting every
// result transaction from a behavioral copy of the machine state. Directed
// programs cover each instruction, cell wrap and both bracket jumps. Random
// programs use pointer-balanced loops that always terminate, so that runs go
// deep into nested jumps. The run ends by forcing one sticky error, chosen at
// random, and checking that it holds.
// ----------------------------------------------------------------------------
module tb;
	import tmie_pkg::*;

	// Small stores keep the clearing pass short and both store limits within reach.
	localparam int TB_TAPE_DEPTH = 32;
	localparam int TB_CODE_DEPTH = 256;
	localparam int RANDOM_ITEMS  = 320;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int HOLD_CYCLES   = 400;

	typedef struct packed {
		logic         emit_valid;
		logic [7:0]   emit_byte;
		logic         feed_taken;
		tmie_status_t status;
	} exec_outcome_t;

	typedef enum int {
		FAULT_PTR_HIGH,
		FAULT_PTR_LOW,
		FAULT_CLOSE,
		FAULT_OPEN,
		FAULT_FULL
	} fault_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tmie_req_if req_ch ();
	tmie_rsp_if rsp_ch ();

	tape_machine_instruction_executor_top #(
		.TAPE_DEPTH(TB_TAPE_DEPTH),
		.CODE_DEPTH(TB_CODE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Machine state as the testbench expects it to be.
	logic [7:0]   tape_m [TB_TAPE_DEPTH];
	logic [7:0]   code_m [TB_CODE_DEPTH];
	int           code_len_m = 0;
	int           ic_m = 0;
	int           ptr_m = 0;
	tmie_status_t status_m = ST_RUN;

	exec_outcome_t outcomes_due [$];
	exec_outcome_t oldest;
	logic [7:0]    frag [$];
	int            gen_ptr = 0;
	int            items_sent = 0;
	int            burst_left = 0;
	int            mismatch_count = 0;
	int            cycle_count = 0;
	int            hold_asks = 0;
	int            hold_seen = 0;
	int            hold_left = 0;
	int            stall_pct = 0;
	int            phase_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Scan from a bracket for its nesting partner; dir is +1 or -1.
	function automatic bit find_partner(input int pos, input int dir, output int hit);
		int level;
		int i;
		level = 0;
		i = pos;
		hit = 0;
		while (i >= 0 && i < code_len_m) begin
			if (code_m[i] == OP_OPEN)
				level += dir;
			if (code_m[i] == OP_CLOSE)
				level -= dir;
			if (level == 0) begin
				hit = i;
				return 1'b1;
			end
			i += dir;
		end
		return 1'b0;
	endfunction

	// Apply one request to the expected state and return the result it causes.
	function automatic exec_outcome_t interpret_request(input logic kind,
		input logic [7:0] cbyte, input logic [7:0] fbyte);
		exec_outcome_t o;
		logic [7:0] op;
		bit advance;
		int hit;
		o = '0;
		if (status_m < ST_PTR) begin
			if (kind == REQ_LOAD) begin
				if (code_len_m >= TB_CODE_DEPTH) begin
					status_m = ST_FULL;
				end else begin
					code_m[code_len_m] = cbyte;
					code_len_m++;
				end
			end else if (ic_m < code_len_m) begin
				op = code_m[ic_m];
				advance = 1'b1;
				case (op)
					OP_RIGHT: begin
						if (ptr_m + 1 >= TB_TAPE_DEPTH) begin
							status_m = ST_PTR;
							advance = 1'b0;
						end else begin
							ptr_m++;
						end
					end
					OP_LEFT: begin
						if (ptr_m == 0) begin
							status_m = ST_PTR;
							advance = 1'b0;
						end else begin
							ptr_m--;
						end
					end
					OP_INC: tape_m[ptr_m] = tape_m[ptr_m] + 8'd1;
					OP_DEC: tape_m[ptr_m] = tape_m[ptr_m] - 8'd1;
					OP_OUT: begin
						o.emit_valid = 1'b1;
						o.emit_byte = tape_m[ptr_m];
					end
					OP_IN: begin
						tape_m[ptr_m] = fbyte;
						o.feed_taken = 1'b1;
					end
					OP_OPEN: begin
						if (tape_m[ptr_m] == 8'd0) begin
							if (find_partner(ic_m, 1, hit)) begin
								ic_m = hit;
							end else begin
								status_m = ST_BRACKET;
								advance = 1'b0;
							end
						end
					end
					OP_CLOSE: begin
						if (tape_m[ptr_m] != 8'd0) begin
							if (find_partner(ic_m, -1, hit)) begin
								ic_m = hit;
							end else begin
								status_m = ST_BRACKET;
								advance = 1'b0;
							end
						end
					end
					default: ;
				endcase
				if (advance)
					ic_m++;
			end
			if (status_m < ST_PTR) begin
				if (ic_m >= code_len_m)
					status_m = ST_HALT;
				else
					status_m = ST_RUN;
			end
		end
		o.status = status_m;
		return o;
	endfunction

	// Offer one request in the current burst and record its result once accepted.
	task automatic send_item(input logic kind, input logic [7:0] cbyte,
		input logic [7:0] fbyte);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.code_byte <= cbyte;
		req_ch.feed_byte <= fbyte;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		outcomes_due.push_back(interpret_request(kind, cbyte, fbyte));
		items_sent++;
	endtask

	task automatic load_fragment();
		foreach (frag[i])
			send_item(REQ_LOAD, frag[i], 8'($urandom_range(255)));
	endtask

	// Feed bytes that land in a cell stay small mostly, so loop counts stay short.
	function automatic logic [7:0] pick_feed();
		if (ic_m < code_len_m && code_m[ic_m] == OP_IN && $urandom_range(7) != 0)
			return 8'($urandom_range(3));
		return 8'($urandom_range(255));
	endfunction

	// Step while the program is running, up to a cap.
	task automatic run_steps(input int cap);
		int k;
		k = 0;
		while (status_m == ST_RUN && k < cap) begin
			send_item(REQ_STEP, 8'($urandom_range(255)), pick_feed());
			k++;
		end
	endtask

	function automatic logic [7:0] noise_char();
		logic [7:0] c;
		do c = 8'($urandom_range(255));
		while (c inside {OP_RIGHT, OP_LEFT, OP_INC, OP_DEC, OP_OUT, OP_IN, OP_OPEN, OP_CLOSE});
		return c;
	endfunction

	function automatic logic [7:0] data_op();
		case ($urandom_range(5))
			0: return OP_INC;
			1: return OP_DEC;
			2: return OP_OUT;
			3: return OP_IN;
			4: return noise_char();
			default: return OP_INC;
		endcase
	endfunction

	// A loop counts its own cell down once per pass and works only on cells to its
	// right, returning the pointer each time, so it always terminates.
	function automatic void add_loop(input int depth);
		int items;
		bit dec_first;
		items = $urandom_range(1, 3);
		dec_first = 1'($urandom_range(1));
		frag.push_back(OP_OPEN);
		if (dec_first)
			frag.push_back(OP_DEC);
		repeat (items) begin
			frag.push_back(OP_RIGHT);
			if (depth < 2 && $urandom_range(3) == 0)
				add_loop(depth + 1);
			else
				frag.push_back(data_op());
			frag.push_back(OP_LEFT);
		end
		if (!dec_first)
			frag.push_back(OP_DEC);
		frag.push_back(OP_CLOSE);
	endfunction

	// Top-level moves are tracked in the code text, since loops leave the pointer
	// where they found it.
	function automatic void build_fragment();
		int n;
		int run;
		frag.delete();
		n = $urandom_range(2, 6);
		repeat (n) begin
			case ($urandom_range(5))
				0, 1: frag.push_back(data_op());
				2, 3: begin
					run = $urandom_range(1, 8);
					if ($urandom_range(1) == 1) begin
						repeat (run) begin
							if (gen_ptr < TB_TAPE_DEPTH - 1) begin
								frag.push_back(OP_RIGHT);
								gen_ptr++;
							end
						end
					end else begin
						repeat (run) begin
							if (gen_ptr > 0) begin
								frag.push_back(OP_LEFT);
								gen_ptr--;
							end
						end
					end
				end
				default: begin
					if (gen_ptr <= TB_TAPE_DEPTH - 3) begin
						add_loop(1);
					end else begin
						frag.push_back(OP_LEFT);
						gen_ptr--;
					end
				end
			endcase
		end
	endfunction

	// Each plain instruction once, with wrap in both directions.
	task automatic test_single_ops();
		send_item(REQ_STEP, 8'hFF, 8'hA5);
		frag = '{OP_IN, OP_INC, OP_DEC, OP_OUT, OP_RIGHT, OP_LEFT};
		load_fragment();
		send_item(REQ_STEP, 8'h00, 8'hFF);
		run_steps(10);
		send_item(REQ_STEP, 8'h00, 8'h00);
	endtask

	// A back jump that repeats a loop, then a forward jump past a loop on zero.
	task automatic test_bracket_jumps();
		frag = '{OP_IN, OP_OPEN, OP_OUT, OP_DEC, OP_CLOSE};
		load_fragment();
		send_item(REQ_STEP, 8'h00, 8'h02);
		run_steps(20);
		frag = '{8'h00, 8'hFF, OP_OPEN, OP_OUT, OP_CLOSE};
		load_fragment();
		run_steps(10);
	endtask

	task automatic test_random_programs();
		int start;
		int saved_ptr;
		bit pressed;
		start = items_sent;
		pressed = 1'b0;
		gen_ptr = ptr_m;
		while (items_sent - start < RANDOM_ITEMS) begin
			// Once, hold the result side off long enough for the input to back up.
			if (!pressed && items_sent - start >= RANDOM_ITEMS / 3) begin
				hold_asks++;
				pressed = 1'b1;
			end
			saved_ptr = gen_ptr;
			build_fragment();
			if (code_len_m + frag.size() <= TB_CODE_DEPTH - 16) begin
				load_fragment();
			end else begin
				gen_ptr = saved_ptr;
				if (status_m != ST_RUN)
					break;
			end
			run_steps($urandom_range(8, 80));
			if (status_m == ST_HALT && $urandom_range(7) == 0)
				send_item(REQ_STEP, 8'($urandom_range(255)), 8'($urandom_range(255)));
		end
	endtask

	// Drive the machine into one sticky error, then check that it holds.
	task automatic test_sticky_fault();
		fault_kind_t kind;
		int guard;
		kind = fault_kind_t'($urandom_range(4));
		run_steps(120);
		// A program still deep in long loops will not reach new code soon.
		if (status_m == ST_RUN)
			kind = FAULT_FULL;
		case (kind)
			FAULT_PTR_HIGH: frag = '{OP_IN, OP_OPEN, OP_RIGHT, OP_IN, OP_CLOSE};
			FAULT_PTR_LOW:  frag = '{OP_IN, OP_OPEN, OP_LEFT, OP_IN, OP_CLOSE};
			FAULT_CLOSE:    frag = '{OP_IN, OP_CLOSE};
			FAULT_OPEN:     frag = '{OP_IN, OP_OPEN};
			default:        frag.delete();
		endcase
		guard = 0;
		if (kind == FAULT_FULL) begin
			while (status_m != ST_FULL && guard < TB_CODE_DEPTH + 2) begin
				send_item(REQ_LOAD, 8'($urandom_range(255)), 8'($urandom_range(255)));
				guard++;
			end
		end else begin
			load_fragment();
			while (status_m < ST_PTR && guard < 500) begin
				send_item(REQ_STEP, 8'($urandom_range(255)),
					(kind == FAULT_OPEN) ? 8'h00 : 8'($urandom_range(1, 255)));
				guard++;
			end
		end
		repeat (6)
			send_item(1'($urandom_range(1)), 8'($urandom_range(255)),
				8'($urandom_range(255)));
	endtask

	initial begin
		foreach (tape_m[i])
			tape_m[i] = 8'd0;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_LOAD;
		req_ch.code_byte <= 8'd0;
		req_ch.feed_byte <= 8'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_single_ops();
		test_bracket_jumps();
		test_random_programs();
		test_sticky_fault();
		req_ch.valid <= 1'b0;
		while (outcomes_due.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (mismatch_count == 0 && outcomes_due.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// Result side: phases of steady or random stalls, plus the long hold-off.
	always @(posedge clk) begin
		if (hold_seen != hold_asks) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			if (phase_left == 0) begin
				case ($urandom_range(2))
					0: stall_pct = 0;
					1: stall_pct = 30;
					default: stall_pct = 75;
				endcase
				phase_left = $urandom_range(16, 160);
			end
			phase_left--;
			rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Compare each result transaction with the oldest outstanding prediction.
	always @(posedge clk) begin
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (outcomes_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display({"Unexpected result: emit_valid=%0d emit_byte=%02h ",
						"feed_taken=%0d status=%0d"},
						rsp_ch.emit_valid, rsp_ch.emit_byte, rsp_ch.feed_taken,
						rsp_ch.status);
			end else begin
				oldest = outcomes_due.pop_front();
				if (rsp_ch.emit_valid !== oldest.emit_valid ||
					rsp_ch.emit_byte !== oldest.emit_byte ||
					rsp_ch.feed_taken !== oldest.feed_taken ||
					rsp_ch.status !== oldest.status) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"Mismatch: expected ev=%0d eb=%02h ft=%0d st=%0d, ",
							"got ev=%0d eb=%02h ft=%0d st=%0d"},
							oldest.emit_valid, oldest.emit_byte, oldest.feed_taken,
							oldest.status, rsp_ch.emit_valid, rsp_ch.emit_byte,
							rsp_ch.feed_taken, rsp_ch.status);
				end
			end
		end
	end

	// Ends a run that hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end
endmodule
